FILE: hdl/mrrb_pkg.sv
// Shared types, constants and register map of the multi-reader ring buffer.
`timescale 1ns / 1ps

package mrrb_pkg;

   // Buffer geometry.
   localparam int DEPTH      = 64;
   localparam int READERS    = 4;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_WIDTH  = $clog2(DEPTH);
   localparam int CNT_WIDTH  = PTR_WIDTH + 1;

   // Field and register widths.
   localparam int RIDX_WIDTH      = 2;
   localparam int MASK_WIDTH      = 4;
   localparam int DEPTH_REG_WIDTH = 7;
   localparam int RCNT_WIDTH      = 3;
   localparam int RATE_WIDTH      = 7;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_IDX_WIDTH   = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DEPTH = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_COUNT = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RATE0 = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RATE1 = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RATE2 = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RATE3 = 3'd5;

   // Register reset values.
   localparam logic [DEPTH_REG_WIDTH-1:0] DEPTH_RESET = 7'd64;
   localparam logic [RCNT_WIDTH-1:0]      COUNT_RESET = 3'd0;
   localparam logic [RATE_WIDTH-1:0]      RATE_RESET  = 7'd1;

   // Request operation codes.
   typedef enum logic {
      OP_SEND = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // Request payload.
   typedef struct packed {
      op_type                  op;
      logic [DATA_WIDTH-1:0]   write_data;
      logic [RIDX_WIDTH-1:0]   reader_index;
   } req_type;

   // Result payload.
   typedef struct packed {
      logic [DATA_WIDTH-1:0]   read_data;
      logic [MASK_WIDTH-1:0]   ready_mask;
      logic                    overflow;
      logic                    empty_read;
      logic                    bad_reader;
      logic                    starvation;
   } rsp_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [DEPTH_REG_WIDTH-1:0]             depth_in_use;
      logic [RCNT_WIDTH-1:0]                  reader_count;
      logic [READERS-1:0][RATE_WIDTH-1:0]     rates;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic stat;
   } cmd_type;

endpackage

FILE: hdl/mrrb_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps

module mrrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read share the one address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/mrrb_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module mrrb_csr import mrrb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   logic [DEPTH_REG_WIDTH-1:0]         depth_ff, depth_in;
   logic [RCNT_WIDTH-1:0]              count_ff, count_in;
   logic [READERS-1:0][RATE_WIDTH-1:0] rate_ff, rate_in;
   logic [CSR_IDX_WIDTH-1:0]           reg_idx;
   logic                               wr_en;

   assign reg_idx = paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Register write decode; indexes beyond the map are dropped.
   always_comb begin
      depth_in = depth_ff;
      count_in = count_ff;
      rate_in  = rate_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DEPTH: depth_in   = pwdata[DEPTH_REG_WIDTH-1:0];
            REG_COUNT: count_in   = pwdata[RCNT_WIDTH-1:0];
            REG_RATE0: rate_in[0] = pwdata[RATE_WIDTH-1:0];
            REG_RATE1: rate_in[1] = pwdata[RATE_WIDTH-1:0];
            REG_RATE2: rate_in[2] = pwdata[RATE_WIDTH-1:0];
            REG_RATE3: rate_in[3] = pwdata[RATE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
         count_ff <= COUNT_RESET;
         for (int r = 0; r < READERS; r++) begin
            rate_ff[r] <= RATE_RESET;
         end
      end else begin
         depth_ff <= depth_in;
         count_ff <= count_in;
         rate_ff  <= rate_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_DEPTH: prdata = CSR_DATA_WIDTH'(depth_ff);
         REG_COUNT: prdata = CSR_DATA_WIDTH'(count_ff);
         REG_RATE0: prdata = CSR_DATA_WIDTH'(rate_ff[0]);
         REG_RATE1: prdata = CSR_DATA_WIDTH'(rate_ff[1]);
         REG_RATE2: prdata = CSR_DATA_WIDTH'(rate_ff[2]);
         REG_RATE3: prdata = CSR_DATA_WIDTH'(rate_ff[3]);
         default:   prdata = '0;
      endcase
   end

   assign cfg.depth_in_use = depth_ff;
   assign cfg.reader_count = count_ff;
   assign cfg.rates        = rate_ff;

endmodule

FILE: hdl/mrrb_ctrl.sv
// Controller state machine that sequences one request at a time.
`timescale 1ns / 1ps

module mrrb_ctrl import mrrb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_STAT = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state: capture, store access, status, then hand over the result.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_STAT;
         ST_STAT: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshake and datapath commands.
   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = req_ready && req_valid;
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.stat    = (state_ff == ST_STAT);

`ifndef SYNTH
   // A captured request is executed in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec)
      else $error("captured request was not executed");

   // Status evaluation follows execution, and the result follows status.
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> cmd.stat ##1 rsp_valid)
      else $error("execution did not lead to a result");

   // No new request is taken while a result is pending.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted with a result pending");
`endif

endmodule

FILE: hdl/mrrb_datapath.sv
// Datapath: pointers, ready flags, buffer store and result register.
`timescale 1ns / 1ps

module mrrb_datapath import mrrb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  cfg_type cfg,
   input  req_type req_data,
   output rsp_type rsp_data
);

   // Clamp the programmed depth to the range the buffer supports.
   function automatic logic [CNT_WIDTH-1:0] eff_depth(input logic [DEPTH_REG_WIDTH-1:0] raw);
      logic [CNT_WIDTH-1:0] d;
      if (raw < DEPTH_REG_WIDTH'(2)) begin
         d = CNT_WIDTH'(2);
      end else if (raw > DEPTH_REG_WIDTH'(DEPTH)) begin
         d = CNT_WIDTH'(DEPTH);
      end else begin
         d = CNT_WIDTH'(raw);
      end
      return d;
   endfunction

   // Step a pointer, wrapping at the depth in use.
   function automatic logic [PTR_WIDTH-1:0] advance(input logic [PTR_WIDTH-1:0] p,
                                                    input logic [CNT_WIDTH-1:0] d);
      logic [CNT_WIDTH-1:0] nxt;
      nxt = {1'b0, p} + CNT_WIDTH'(1);
      return (nxt >= d) ? '0 : nxt[PTR_WIDTH-1:0];
   endfunction

   // Words held for a reader; a gap larger than the depth counts as empty.
   function automatic logic [CNT_WIDTH-1:0] occupancy(input logic [PTR_WIDTH-1:0] wp,
                                                      input logic [PTR_WIDTH-1:0] rp,
                                                      input logic [CNT_WIDTH-1:0] d);
      logic [PTR_WIDTH-1:0] gap;
      logic [CNT_WIDTH-1:0] occ;
      gap = rp - wp;
      if (wp >= rp) begin
         occ = {1'b0, wp - rp};
      end else if ({1'b0, gap} > d) begin
         occ = '0;
      end else begin
         occ = d - {1'b0, gap};
      end
      return occ;
   endfunction

   req_type                           req_ff;
   logic [PTR_WIDTH-1:0]              wp_ff, wp_in;
   logic [READERS-1:0][PTR_WIDTH-1:0] rp_ff, rp_in;
   logic [READERS-1:0]                flag_ff, flag_in;
   logic                              ovf_ff, ovf_in;
   logic                              empty_ff, empty_in;
   logic                              bad_ff, bad_in;
   logic                              rd_ok_ff, rd_ok_in;
   rsp_type                           rsp_ff;

   logic [CNT_WIDTH-1:0]              depth_eff;
   logic [RCNT_WIDTH-1:0]             count_eff;
   logic [READERS-1:0]                active;
   logic                              is_send;
   logic                              idx_ok;
   logic [PTR_WIDTH-1:0]              wp_adv;
   logic [PTR_WIDTH-1:0]              rp_sel;
   logic [PTR_WIDTH-1:0]              rp_adv;
   logic [RATE_WIDTH-1:0]             rate_sel;
   logic                              ram_we;
   logic                              ram_re;
   logic [PTR_WIDTH-1:0]              ram_addr;
   logic [DATA_WIDTH-1:0]             ram_rdata;
   logic                              starve;
   logic [READERS-1:0]                mask;

   // Effective configuration.
   assign depth_eff = eff_depth(cfg.depth_in_use);
   assign count_eff = (cfg.reader_count > RCNT_WIDTH'(READERS)) ?
                      RCNT_WIDTH'(READERS) : cfg.reader_count;

   always_comb begin
      for (int r = 0; r < READERS; r++) begin
         active[r] = RCNT_WIDTH'(r) < count_eff;
      end
   end

   // Request decode and pointer steps.
   assign is_send  = (req_ff.op == OP_SEND);
   assign idx_ok   = RCNT_WIDTH'(req_ff.reader_index) < count_eff;
   assign wp_adv   = advance(wp_ff, depth_eff);
   assign rp_sel   = rp_ff[req_ff.reader_index];
   assign rp_adv   = advance(rp_sel, depth_eff);
   assign rate_sel = cfg.rates[req_ff.reader_index];

   // Store access during execution.
   assign ram_we   = cmd.exec && is_send;
   assign ram_re   = cmd.exec && !is_send && idx_ok;
   assign ram_addr = is_send ? wp_ff : rp_sel;

   mrrb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (req_ff.write_data),
      .rdata (ram_rdata)
   );

   // Execution: update pointers and ready flags, record the per-request flags.
   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      flag_in  = flag_ff;
      ovf_in   = ovf_ff;
      empty_in = empty_ff;
      bad_in   = bad_ff;
      rd_ok_in = rd_ok_ff;
      if (cmd.exec) begin
         ovf_in   = 1'b0;
         empty_in = 1'b0;
         bad_in   = 1'b0;
         rd_ok_in = 1'b0;
         if (is_send) begin
            wp_in = wp_adv;
            for (int r = 0; r < READERS; r++) begin
               if (active[r]) begin
                  if (wp_adv == rp_ff[r]) ovf_in = 1'b1;
                  if (occupancy(wp_adv, rp_ff[r], depth_eff) >= CNT_WIDTH'(cfg.rates[r])) begin
                     flag_in[r] = 1'b1;
                  end
               end
            end
         end else if (!idx_ok) begin
            bad_in = 1'b1;
         end else begin
            empty_in                    = (rp_sel == wp_ff);
            rd_ok_in                    = 1'b1;
            rp_in[req_ff.reader_index]  = rp_adv;
            if (occupancy(wp_ff, rp_adv, depth_eff) < CNT_WIDTH'(rate_sel)) begin
               flag_in[req_ff.reader_index] = 1'b0;
            end
         end
      end
   end

   // Status over the updated state.
   always_comb begin
      starve = 1'b0;
      for (int r = 0; r < READERS; r++) begin
         mask[r] = flag_ff[r] && active[r];
         if (active[r] &&
             (occupancy(wp_ff, rp_ff[r], depth_eff) < CNT_WIDTH'(cfg.rates[r]))) begin
            starve = 1'b1;
         end
      end
   end

   // Control state: pointers and flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         flag_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         flag_ff <= flag_in;
      end
   end

   // Payload registers: captured request, request flags and result.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      ovf_ff   <= ovf_in;
      empty_ff <= empty_in;
      bad_ff   <= bad_in;
      rd_ok_ff <= rd_ok_in;
      if (cmd.stat) begin
         rsp_ff.read_data  <= rd_ok_ff ? ram_rdata : '0;
         rsp_ff.ready_mask <= MASK_WIDTH'(mask);
         rsp_ff.overflow   <= ovf_ff;
         rsp_ff.empty_read <= empty_ff;
         rsp_ff.bad_reader <= bad_ff;
         rsp_ff.starvation <= starve;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   // The write pointer moves only as a result of executing a request.
   assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(wp_ff))
      else $error("write pointer moved outside execution");

   // A read request never moves the write pointer.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !is_send) |=> $stable(wp_ff))
      else $error("write pointer moved on a read");
`endif

endmodule

FILE: hdl/multi_reader_ring_buffer.sv
// Top level of the multi-reader broadcast ring buffer.
// One writer and up to four readers share a 64-word circular store.
// Request channel (req_valid/req_ready/req_data): op selects a send of
// write_data or a read for reader_index. Result channel (rsp_valid/rsp_ready/
// rsp_data): one result per request with the read word, the ready mask and
// the overflow, empty read, bad reader and starvation flags.
// The configuration port (psel/penable/pwrite/paddr/pwdata/prdata/pready)
// holds depth in use, reader count and four reader rates at 4-byte steps;
// write it only while no request is in flight.
// An accepted request passes through the execute and status states before
// its result is valid; no new request is taken until it is handed over.
// The controller sequence is capture, one access of the single-port store
// with the pointer update, status evaluation and hand-over.
// Reset clears the pointers and ready flags and loads the register defaults;
// the store content is undefined until written, and no clearing pass runs.
// While the receiver stalls, the result holds and no new request is taken.
`timescale 1ns / 1ps

module multi_reader_ring_buffer import mrrb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type cfg;
   cmd_type cmd;

   // Configuration registers.
   mrrb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Request sequencing.
   mrrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Pointers, flags and store.
   mrrb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
